/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the checker file gfmr_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gfmr_pkg.sv */
// ----------------------------------------------------------------------------
// gfmr_pkg
// Shared constants and types of the GF(2^M) multiply / reciprocal unit.
// ----------------------------------------------------------------------------
package gfmr_pkg;

  localparam int FIELD_SIZE_DEFAULT = 256;

  // stream payload
  localparam int OPERAND_W = 8;
  localparam int RESULT_W  = 8;

  // opcodes (in_tuser)
  localparam logic OP_MUL   = 1'b0;
  localparam logic OP_RECIP = 1'b1;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int POLY_W     = 9;
  localparam logic [POLY_W-1:0] POLY_RESET = 9'd285;
  localparam logic [CFG_DATA_W-1:0] POLY_MASK = CFG_DATA_W'((1 << POLY_W) - 1);
  // register word index = paddr[CFG_ADDR_W-1:2]
  localparam logic [CFG_ADDR_W-3:0] CFG_IDX_POLY = '0;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH) + 1;

  // table rebuild sequencer
  typedef enum logic [1:0] {
    BLD_CLEAR,
    BLD_GEN,
    BLD_DONE
  } build_state_t;

endpackage

/* rtl/gfmr_tables.sv */
// ----------------------------------------------------------------------------
// gfmr_tables
// Log and antilog memories with the sequencer that rebuilds them from the
// field polynomial: a clearing sweep, then one power of alpha per cycle.
// ----------------------------------------------------------------------------
module gfmr_tables #(
  parameter  int FIELD_SIZE = gfmr_pkg::FIELD_SIZE_DEFAULT,
  localparam int IDX_W      = $clog2(FIELD_SIZE)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rebuild,
  input  logic [IDX_W-1:0] poly,
  output logic             busy,
  input  logic [IDX_W-1:0] log_addr_a,
  input  logic [IDX_W-1:0] log_addr_b,
  output logic [IDX_W-1:0] log_data_a,
  output logic [IDX_W-1:0] log_data_b,
  input  logic [IDX_W-1:0] alog_addr,
  output logic [IDX_W-1:0] alog_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIELD_SIZE - 1);
  localparam logic [IDX_W-1:0] GEN_LAST = IDX_W'(FIELD_SIZE - 2);
  localparam logic [IDX_W-1:0] ONE      = IDX_W'(1);

  gfmr_pkg::build_state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] pow_r, pow_nxt;
  logic [IDX_W-1:0] next_pow;

  logic             wr_en;
  logic [IDX_W-1:0] log_wa, log_wd, alog_wa, alog_wd;

  logic [IDX_W-1:0] log_mem  [FIELD_SIZE];
  logic [IDX_W-1:0] alog_mem [FIELD_SIZE];
  logic [IDX_W-1:0] log_rd_a_r, log_rd_b_r, alog_rd_r;

  // alpha times current power, reduced by the polynomial
  assign next_pow = {pow_r[IDX_W-2:0], 1'b0} ^ (pow_r[IDX_W-1] ? poly : '0);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pow_nxt   = pow_r;
    priority if (rebuild) begin
      state_nxt = gfmr_pkg::BLD_CLEAR;
      idx_nxt   = '0;
    end else begin
      unique case (state_r)
        gfmr_pkg::BLD_CLEAR: begin
          idx_nxt = idx_r + ONE;
          if (idx_r == LAST_IDX) begin
            state_nxt = gfmr_pkg::BLD_GEN;
            idx_nxt   = ONE;
            pow_nxt   = ONE;
          end
        end
        gfmr_pkg::BLD_GEN: begin
          idx_nxt = idx_r + ONE;
          pow_nxt = next_pow;
          if (idx_r == GEN_LAST) begin
            state_nxt = gfmr_pkg::BLD_DONE;
          end
        end
        gfmr_pkg::BLD_DONE: begin
        end
        default: begin
          state_nxt = gfmr_pkg::BLD_CLEAR;
          idx_nxt   = '0;
        end
      endcase
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    log_wa  = idx_r;
    log_wd  = '0;
    alog_wa = idx_r;
    alog_wd = '0;
    unique case (state_r)
      gfmr_pkg::BLD_CLEAR: begin
        // alpha^0 and the wrap entry both read as 1
        wr_en   = 1'b1;
        alog_wd = (idx_r == '0 || idx_r == LAST_IDX) ? ONE : '0;
      end
      gfmr_pkg::BLD_GEN: begin
        wr_en   = 1'b1;
        alog_wd = next_pow;
        log_wa  = next_pow;
        log_wd  = idx_r;
      end
      gfmr_pkg::BLD_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign busy = (state_r != gfmr_pkg::BLD_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gfmr_pkg::BLD_CLEAR;
      idx_r   <= '0;
      pow_r   <= ONE;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pow_r   <= pow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      log_mem[log_wa] <= log_wd;
    end
  end

  always_ff @(posedge clk) begin
    log_rd_a_r <= log_mem[log_addr_a];
    log_rd_b_r <= log_mem[log_addr_b];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      alog_mem[alog_wa] <= alog_wd;
    end
  end

  always_ff @(posedge clk) begin
    alog_rd_r <= alog_mem[alog_addr];
  end

  assign log_data_a = log_rd_a_r;
  assign log_data_b = log_rd_b_r;
  assign alog_data  = alog_rd_r;

endmodule

/* rtl/galois_field_mul_recip_unit.sv */
// ----------------------------------------------------------------------------
// galois_field_mul_recip_unit
// GF(2^M) multiply / reciprocal unit on log and antilog tables.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request stream. tdata = {operand_b, operand_a}, tuser = opcode
//           (0 multiply, 1 reciprocal of operand_a).
//   out_* : result stream. tdata = result_value, tuser = zero_inverse.
//   cfg_* : APB-style port, one register at byte address 0, the field
//           polynomial (9 bits, reset 0x11D). Writing it rebuilds the tables.
// Throughput is one request per cycle while in_tready is high; a request
// passes log memory read, antilog memory read and result queue to out_tvalid.
// After reset and after every polynomial write the table sequencer first
// clears the memories and then generates the powers of alpha; in_tready
// stays low for that time.
// Results go into a 4-entry queue. Requests keep being accepted while the
// receiver stalls until requests in flight plus queued results reach four,
// then in_tready drops; nothing is lost or repeated.
// Polynomial writes are meant for an idle unit only.
// ----------------------------------------------------------------------------
module galois_field_mul_recip_unit #(
  parameter int FIELD_SIZE = gfmr_pkg::FIELD_SIZE_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [2*gfmr_pkg::OPERAND_W-1:0]    in_tdata,   // [7:0] operand_a, [15:8] operand_b
  input  logic [0:0]                          in_tuser,   // [0] opcode
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [gfmr_pkg::RESULT_W-1:0]       out_tdata,  // [7:0] result_value
  output logic [0:0]                          out_tuser,  // [0] zero_inverse
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [gfmr_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [gfmr_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [gfmr_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int IDX_W = $clog2(FIELD_SIZE);
  localparam int SUM_W = IDX_W + 1;
  localparam logic [SUM_W-1:0] ORDER_S = SUM_W'(FIELD_SIZE - 1);
  localparam logic [IDX_W-1:0] ORDER_I = IDX_W'(FIELD_SIZE - 1);

  // ---------------------------------------------------------------- config
  logic [gfmr_pkg::POLY_W-1:0] poly_r, poly_nxt;
  logic                        cfg_word_poly;
  logic                        poly_wr;

  assign cfg_pready    = 1'b1;
  assign cfg_word_poly = (cfg_paddr[gfmr_pkg::CFG_ADDR_W-1:2] == gfmr_pkg::CFG_IDX_POLY);
  assign poly_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_word_poly;
  assign poly_nxt      = poly_wr ? cfg_pwdata[gfmr_pkg::POLY_W-1:0] : poly_r;
  assign cfg_prdata    = cfg_word_poly ? gfmr_pkg::CFG_DATA_W'(poly_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= gfmr_pkg::POLY_RESET;
    end else begin
      poly_r <= poly_nxt;
    end
  end

  // ---------------------------------------------------------------- tables
  logic             tbl_busy;
  logic [IDX_W-1:0] op_a, op_b;
  logic [IDX_W-1:0] log_a, log_b;
  logic [IDX_W-1:0] alog_addr, alog_data;

  // operands reduced modulo FIELD_SIZE
  assign op_a = in_tdata[IDX_W-1:0];
  assign op_b = in_tdata[gfmr_pkg::OPERAND_W +: IDX_W];

  gfmr_tables #(
    .FIELD_SIZE (FIELD_SIZE)
  ) u_tables (
    .clk        (clk),
    .rst_n      (rst_n),
    .rebuild    (poly_wr),
    .poly       (poly_r[IDX_W-1:0]),
    .busy       (tbl_busy),
    .log_addr_a (op_a),
    .log_addr_b (op_b),
    .log_data_a (log_a),
    .log_data_b (log_b),
    .alog_addr  (alog_addr),
    .alog_data  (alog_data)
  );

  // ---------------------------------------------------------------- pipe
  logic in_fire;
  logic s1_v_r, s1_v_nxt;
  logic s1_op_r, s1_a_zero_r, s1_b_zero_r;
  logic s2_v_r, s2_v_nxt;
  logic s2_zero_r, s2_flag_r;

  logic [SUM_W-1:0] lsum, lsum_red;
  logic [IDX_W-1:0] mul_addr, recip_addr;
  logic [IDX_W-1:0] res_val;

  // tables are read-only while requests flow; the rebuild holds in_tready low
  assign in_fire  = in_tvalid && in_tready;
  assign s1_v_nxt = in_fire;
  assign s2_v_nxt = s1_v_r;

  assign lsum       = {1'b0, log_a} + {1'b0, log_b};
  assign lsum_red   = lsum - ORDER_S;
  assign mul_addr   = (lsum > ORDER_S) ? lsum_red[IDX_W-1:0] : lsum[IDX_W-1:0];
  assign recip_addr = ORDER_I - log_a;
  assign alog_addr  = (s1_op_r == gfmr_pkg::OP_RECIP) ? recip_addr : mul_addr;

  always_ff @(posedge clk) begin
    s1_op_r     <= in_tuser[0];
    s1_a_zero_r <= (op_a == '0);
    s1_b_zero_r <= (op_b == '0);
    s2_zero_r   <= (s1_op_r == gfmr_pkg::OP_MUL) && (s1_a_zero_r || s1_b_zero_r);
    s2_flag_r   <= (s1_op_r == gfmr_pkg::OP_RECIP) && s1_a_zero_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  assign res_val = s2_zero_r ? '0 : alog_data;

  // ---------------------------------------------------------------- queue
  logic [IDX_W-1:0]               q_val_r  [gfmr_pkg::FIFO_DEPTH];
  logic                           q_flag_r [gfmr_pkg::FIFO_DEPTH];
  logic [gfmr_pkg::FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [gfmr_pkg::FIFO_CNT_W-1:0] cnt_r, cnt_nxt, inflight;
  logic                           push, pop;

  assign push = s2_v_r;
  assign pop  = out_tvalid && out_tready;

  assign wr_ptr_nxt = wr_ptr_r + gfmr_pkg::FIFO_PTR_W'(push);
  assign rd_ptr_nxt = rd_ptr_r + gfmr_pkg::FIFO_PTR_W'(pop);
  assign cnt_nxt    = cnt_r + gfmr_pkg::FIFO_CNT_W'(push) - gfmr_pkg::FIFO_CNT_W'(pop);

  // credit: every request in the pipe has a queue slot reserved
  assign inflight  = cnt_r + gfmr_pkg::FIFO_CNT_W'(s1_v_r) + gfmr_pkg::FIFO_CNT_W'(s2_v_r);
  assign in_tready = !tbl_busy &&
                     (inflight < gfmr_pkg::FIFO_CNT_W'(gfmr_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      q_val_r[wr_ptr_r]  <= res_val;
      q_flag_r[wr_ptr_r] <= s2_flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign out_tvalid   = (cnt_r != '0);
  assign out_tdata    = gfmr_pkg::RESULT_W'(q_val_r[rd_ptr_r]);
  assign out_tuser[0] = q_flag_r[rd_ptr_r];

endmodule

/* rtl/gfmr_checker.sv */
// ----------------------------------------------------------------------------
// gfmr_checker
// Port-level checks of the multiply / reciprocal unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gfmr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [2*gfmr_pkg::OPERAND_W-1:0]    in_tdata,
  input logic [0:0]                          in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [gfmr_pkg::RESULT_W-1:0]       out_tdata,
  input logic [0:0]                          out_tuser,
  input logic                                cfg_psel,
  input logic                                cfg_penable,
  input logic                                cfg_pwrite,
  input logic [gfmr_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input logic [gfmr_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  input logic [gfmr_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  input logic                                cfg_pready
);

  logic in_acc;
  logic poly_wr;
  logic word_poly;

  assign in_acc    = in_tvalid && in_tready;
  assign word_poly = (cfg_paddr[gfmr_pkg::CFG_ADDR_W-1:2] == gfmr_pkg::CFG_IDX_POLY);
  assign poly_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && word_poly;

  // a stalled result holds
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // a polynomial write starts a table rebuild that blocks requests
  `ASSERT_NXT(a_rebuild_blocks, clk, rst_n, poly_wr, !in_tready, "request accepted during table rebuild")

  // the first result of a burst comes through log read, antilog read and queue after its request
  `ASSERT_IMP(a_out_latency, clk, rst_n, $rose(out_tvalid), $past(in_acc, 3), "result without matching request")

  // the polynomial register reads back what was written
  `ASSERT_NXT(a_poly_readback, clk, rst_n, poly_wr, !word_poly || (cfg_prdata == ($past(cfg_pwdata) & gfmr_pkg::POLY_MASK)), "polynomial readback mismatch")

endmodule

bind galois_field_mul_recip_unit gfmr_checker u_gfmr_checker (.*);

/* tb/galois_field_mul_recip_unit_test.sv */
// ----------------------------------------------------------------------------
// galois_field_mul_recip_unit_test
// Self-checking bench for the GF(2^8) multiply / reciprocal unit. Requests are
// streamed in bursts under several field polynomials, including the extremes
// 0 and 0x1FF and polynomials that are not primitive. A scoreboard keeps its
// own log / antilog tables, predicts every result and compares each returned
// result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module galois_field_mul_recip_unit_test;

  localparam int CLK_PERIOD   = 20;
  localparam int PIPE_LATENCY = 3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 285;
  localparam int HOLD_AT      = 700;   // results seen before the long receiver hold
  localparam int HOLD_CYCLES  = 400;
  localparam logic [gfmr_pkg::CFG_ADDR_W-1:0] POLY_ADDR = {gfmr_pkg::CFG_IDX_POLY, 2'b00};
  localparam logic [gfmr_pkg::CFG_ADDR_W-1:0] UNMAPPED_ADDR = POLY_ADDR + 3'd4;

  typedef struct packed {
    logic [gfmr_pkg::RESULT_W-1:0] value;
    logic                          zero_inv;
  } gf_result_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  class gf_product_checker;
    logic [gfmr_pkg::POLY_W-1:0]    poly;
    logic [gfmr_pkg::OPERAND_W-1:0] antilog[256];
    logic [gfmr_pkg::OPERAND_W-1:0] log_of[256];
    gf_result_t                     pending_results[$];
    int                             mismatches;

    // powers of alpha by shift and conditional xor; unreached logs stay 0
    function void load_polynomial(logic [gfmr_pkg::POLY_W-1:0] p);
      logic [8:0] v;
      poly = p;
      foreach (log_of[k]) begin
        log_of[k]  = '0;
        antilog[k] = '0;
      end
      antilog[0]   = 8'd1;
      antilog[255] = 8'd1;
      for (int i = 1; i < 255; i++) begin
        v = {antilog[i-1], 1'b0};
        if (v[8]) v = v ^ poly;
        antilog[i]      = v[7:0];
        log_of[v[7:0]]  = i[7:0];
      end
    endfunction

    function void note_request(logic op, logic [gfmr_pkg::OPERAND_W-1:0] a,
                               logic [gfmr_pkg::OPERAND_W-1:0] b);
      gf_result_t r;
      logic [9:0] log_sum;
      r.zero_inv = 1'b0;
      if (op == gfmr_pkg::OP_MUL) begin
        if (a == 0 || b == 0) begin
          r.value = '0;
        end else begin
          log_sum = {2'b00, log_of[a]} + {2'b00, log_of[b]};
          if (log_sum > 10'd255) log_sum = log_sum - 10'd255;
          r.value = antilog[log_sum[7:0]];
        end
      end else begin
        r.zero_inv = (a == 0);
        r.value    = antilog[8'd255 - log_of[a]];
      end
      pending_results.push_back(r);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected 0x%0h, got 0x%0h", what, want, got);
    endfunction

    function void check_result(logic [gfmr_pkg::RESULT_W-1:0] value, logic zero_inv);
      gf_result_t e;
      if (pending_results.size() == 0) begin
        report("result with no request pending", 32'd0, 32'(value));
        return;
      end
      e = pending_results.pop_front();
      if (value !== e.value) report("result_value", 32'(e.value), 32'(value));
      if (zero_inv !== e.zero_inv)
        report("zero_inverse", 32'(e.zero_inv), 32'(zero_inv));
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [2*gfmr_pkg::OPERAND_W-1:0]    in_tdata = '0;    // [7:0] operand_a, [15:8] operand_b
  logic [0:0]                          in_tuser = '0;    // [0] opcode
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [gfmr_pkg::RESULT_W-1:0]       out_tdata;        // [7:0] result_value
  logic [0:0]                          out_tuser;        // [0] zero_inverse
  logic                                cfg_psel = 1'b0;
  logic                                cfg_penable = 1'b0;
  logic                                cfg_pwrite = 1'b0;
  logic [gfmr_pkg::CFG_ADDR_W-1:0]     cfg_paddr = '0;
  logic [gfmr_pkg::CFG_DATA_W-1:0]     cfg_pwdata = '0;
  logic [gfmr_pkg::CFG_DATA_W-1:0]     cfg_prdata;
  logic                                cfg_pready;

  gf_product_checker board = new();
  int cycle_count  = 0;
  int results_seen = 0;
  int burst_left   = 0;
  int max_gap      = 0;

  galois_field_mul_recip_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #(CLK_PERIOD/2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** galois_field_mul_recip_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      board.note_request(in_tuser[0], in_tdata[7:0], in_tdata[15:8]);
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tdata, out_tuser[0]);
      results_seen <= results_seen + 1;
    end
  end

  // receiver: shifting stall pattern, plus one long hold to fill the unit
  initial begin
    rx_mode_t mode;
    int mode_left;
    int hold_left;
    bit held;
    mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(64, 256);
        end
        mode_left--;
        case (mode)
          RX_OPEN:     out_tready <= 1'b1;
          RX_RANDOM:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE:   out_tready <= ($urandom_range(0, 3) == 0);
          default:     out_tready <= (cycle_count % 5 != 0);
        endcase
      end
    end
  end

  task automatic send_request(logic op, logic [gfmr_pkg::OPERAND_W-1:0] a,
                              logic [gfmr_pkg::OPERAND_W-1:0] b);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {b, a};
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else if (max_gap > 0) begin
      gap = $urandom_range(1, max_gap);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // drain every pending result, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic cfg_write(logic [gfmr_pkg::CFG_ADDR_W-1:0] addr,
                           logic [gfmr_pkg::CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == POLY_ADDR) board.load_polynomial(data[gfmr_pkg::POLY_W-1:0]);
    @(posedge clk);
  endtask

  task automatic cfg_check_poly();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= POLY_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {{(gfmr_pkg::CFG_DATA_W-gfmr_pkg::POLY_W){1'b0}}, board.poly})
      board.report("field_polynomial readback", 32'(board.poly), cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [gfmr_pkg::OPERAND_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_request(1'($urandom_range(0, 1)), pick_element(), pick_element());
  endtask

  initial begin
    logic [gfmr_pkg::POLY_W-1:0] polys[6];
    logic [gfmr_pkg::CFG_DATA_W-1:0] wdata;
    board.load_polynomial(gfmr_pkg::POLY_RESET);
    polys = '{9'h187, 9'h000, 9'h1FF, 9'h100, 9'h000, gfmr_pkg::POLY_RESET};
    polys[4] = 9'($urandom_range(0, 511));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_check_poly();

    // operand extremes, zero operands, log sum of exactly 255 and above it
    send_request(gfmr_pkg::OP_MUL,   8'h00, 8'h00);
    send_request(gfmr_pkg::OP_MUL,   8'h00, 8'h5A);
    send_request(gfmr_pkg::OP_MUL,   8'hA5, 8'h00);
    send_request(gfmr_pkg::OP_MUL,   8'h01, 8'h01);
    send_request(gfmr_pkg::OP_MUL,   8'hFF, 8'hFF);
    send_request(gfmr_pkg::OP_MUL,   8'hFF, 8'h01);
    send_request(gfmr_pkg::OP_MUL,   8'h02, 8'h80);
    send_request(gfmr_pkg::OP_MUL,   8'h02, 8'h8E);
    send_request(gfmr_pkg::OP_MUL,   8'h8E, 8'h8E);
    send_request(gfmr_pkg::OP_MUL,   8'h80, 8'h80);
    send_request(gfmr_pkg::OP_MUL,   8'h55, 8'hAA);
    send_request(gfmr_pkg::OP_RECIP, 8'h00, 8'h00);
    send_request(gfmr_pkg::OP_RECIP, 8'h00, 8'hFF);
    send_request(gfmr_pkg::OP_RECIP, 8'h01, 8'h33);
    send_request(gfmr_pkg::OP_RECIP, 8'h02, 8'h00);
    send_request(gfmr_pkg::OP_RECIP, 8'hFF, 8'hFF);
    send_request(gfmr_pkg::OP_RECIP, 8'h8E, 8'h01);

    max_gap = 0;
    send_random(PHASE_ITEMS);
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      // stray upper data bits must be dropped by the register
      wdata = $urandom();
      wdata[gfmr_pkg::POLY_W-1:0] = polys[p];
      if (p % 2 == 1) wdata[gfmr_pkg::CFG_DATA_W-1:gfmr_pkg::POLY_W] = '0;
      cfg_write(POLY_ADDR, wdata);
      if (p == 2) cfg_write(UNMAPPED_ADDR, 32'h0000_0155);
      cfg_check_poly();
      max_gap = (p == 3) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      send_random(PHASE_ITEMS);
    end

    in_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("** galois_field_mul_recip_unit: PASSED **");
    end else begin
      $display("** galois_field_mul_recip_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/gfmr_pkg.sv
rtl/gfmr_tables.sv
rtl/galois_field_mul_recip_unit.sv
rtl/gfmr_checker.sv
tb/galois_field_mul_recip_unit_test.sv
